// ----- rtl/sapt_pkg.sv -----
`timescale 1ns / 1ps
package sapt_pkg;

	localparam int unsigned ADDR_W = 48;
	localparam int unsigned REF_W  = 32;

	// item kinds
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	// one stored record
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [REF_W-1:0]  name_ref;
		logic [REF_W-1:0]  layout_ref;
	} sapt_rec_t;

	localparam int unsigned REC_W = $bits(sapt_rec_t);

endpackage

// ----- rtl/sorted_address_predecessor_table.sv -----
`timescale 1ns / 1ps
// sorted address predecessor table
//
// input channel (item_valid / item_stall): kind 0 inserts a record
// {code_addr, name_ref, layout_ref}, kind 1 looks up the record with the
// greatest address not above code_addr. every input beat yields exactly one
// result beat on the output channel (result_valid / result_stall).
// records live in one single-port-read memory, sorted by address; equal
// addresses keep insertion order and a lookup returns the earliest of them.
// each binary search step is a memory read then a compare, and a search
// ends when its bounds meet. a lookup runs up to two searches, reads
// back a record after each and then hands off the result. an insert runs
// one search, moves every record above the insert point up one slot
// (read, then write), then writes the new record and hands off. a full-table
// insert skips the search and goes straight from accept to the hand-off.
// one item is worked at a time; item_stall stays high until the result has
// been moved to the output register, which may still hold a result that the
// receiver stalls while the next item is accepted.
// reset empties the table (record count to zero) and drops any pending
// result; record storage itself is not cleared.
module sorted_address_predecessor_table #(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       kind,
	input  logic [sapt_pkg::ADDR_W-1:0] code_addr,
	input  logic [sapt_pkg::REF_W-1:0]  name_ref,
	input  logic [sapt_pkg::REF_W-1:0]  layout_ref,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       found,
	output logic                       exact,
	output logic [sapt_pkg::ADDR_W-1:0] match_addr,
	output logic [sapt_pkg::REF_W-1:0]  match_name_ref,
	output logic [sapt_pkg::REF_W-1:0]  match_layout_ref,
	output logic                       table_full
);

	import sapt_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRCH,   // issue read of mid, or finish the search
		ST_CMP,    // compare record at mid against key
		ST_PRED,   // predecessor record returned, start lower-bound search
		ST_HIT,    // final record returned
		ST_SHIFT,  // read record below the hole, or drop in the new record
		ST_SHWR,   // write moved record one slot up
		ST_DONE    // hand result to output register
	} state_t;

	typedef enum logic [1:0] {
		PH_INS,    // upper bound for insert position
		PH_LK1,    // upper bound for lookup
		PH_LK2     // lower bound of the predecessor address
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [AW-1:0]     mid_q;
	logic [CW-1:0]     idx_q;
	logic [ADDR_W-1:0] key_q;
	sapt_rec_t         item_q;

	// pending result
	logic              res_found_q;
	logic              res_exact_q;
	logic              res_full_q;
	sapt_rec_t         res_rec_q;

	logic              ram_wr_en;
	logic [AW-1:0]     ram_wr_addr;
	sapt_rec_t         ram_wr_data;
	logic              ram_rd_en;
	logic [AW-1:0]     ram_rd_addr;
	sapt_rec_t         ram_rd_data;

	logic [CW:0]       mid_sum;
	logic [AW-1:0]     mid_w;
	logic              srch_busy;
	logic              cmp_hit;
	logic [AW-1:0]     lo_m1;
	logic [AW-1:0]     idx_m1;
	logic              out_free;

	sapt_ram #(
		.WIDTH (REC_W),
		.DEPTH (TABLE_DEPTH)
	) u_rec_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// shared search datapath: midpoint and one address compare
	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w     = mid_sum[AW:1];
	assign srch_busy = (lo_q < hi_q);
	assign cmp_hit   = (phase_q == PH_LK2) ? (ram_rd_data.addr < key_q)
	                                       : (ram_rd_data.addr <= key_q);
	assign lo_m1     = AW'(lo_q - CW'(1));
	assign idx_m1    = AW'(idx_q - CW'(1));
	assign out_free  = !result_valid || !result_stall;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = '0;
		case (state_q)
			ST_SRCH: begin
				if (srch_busy) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = mid_w;
				end else if (phase_q == PH_LK1 && lo_q != '0) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = lo_m1;
				end else if (phase_q == PH_LK2) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = lo_q[AW-1:0];
				end
			end
			ST_SHIFT: begin
				if (idx_q > lo_q) begin
					ram_rd_en   = 1'b1;
					ram_rd_addr = idx_m1;
				end else begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = lo_q[AW-1:0];
					ram_wr_data = item_q;
				end
			end
			ST_SHWR: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = idx_q[AW-1:0];
				ram_wr_data = ram_rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= PH_INS;
			count_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			// the hand-off state drives result_valid itself
			if (result_valid && !result_stall && state_q != ST_DONE) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						item_q      <= '{addr: code_addr, name_ref: name_ref,
						                 layout_ref: layout_ref};
						key_q       <= code_addr;
						lo_q        <= '0;
						hi_q        <= count_q;
						res_found_q <= 1'b0;
						res_exact_q <= 1'b0;
						res_full_q  <= 1'b0;
						res_rec_q   <= '0;
						if (kind == KIND_LOOKUP) begin
							phase_q <= PH_LK1;
							state_q <= ST_SRCH;
						end else if (count_q == CW'(TABLE_DEPTH)) begin
							// no room: reject and flag
							res_full_q <= 1'b1;
							state_q    <= ST_DONE;
						end else begin
							phase_q <= PH_INS;
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (srch_busy) begin
						mid_q   <= mid_w;
						state_q <= ST_CMP;
					end else begin
						case (phase_q)
							PH_INS: begin
								idx_q   <= count_q;
								state_q <= ST_SHIFT;
							end
							PH_LK1: begin
								// nothing at or below the query
								state_q <= (lo_q == '0) ? ST_DONE : ST_PRED;
							end
							PH_LK2: begin
								state_q <= ST_HIT;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_CMP: begin
					if (cmp_hit) begin
						lo_q <= CW'(mid_q) + CW'(1);
					end else begin
						hi_q <= CW'(mid_q);
					end
					state_q <= ST_SRCH;
				end
				ST_PRED: begin
					// search for the first record carrying this address
					key_q   <= ram_rd_data.addr;
					lo_q    <= '0;
					hi_q    <= count_q;
					phase_q <= PH_LK2;
					state_q <= ST_SRCH;
				end
				ST_HIT: begin
					res_found_q <= 1'b1;
					res_exact_q <= (ram_rd_data.addr == item_q.addr);
					res_rec_q   <= ram_rd_data;
					state_q     <= ST_DONE;
				end
				ST_SHIFT: begin
					if (idx_q > lo_q) begin
						state_q <= ST_SHWR;
					end else begin
						count_q <= count_q + CW'(1);
						state_q <= ST_DONE;
					end
				end
				ST_SHWR: begin
					idx_q   <= idx_q - CW'(1);
					state_q <= ST_SHIFT;
				end
				ST_DONE: begin
					if (out_free) begin
						result_valid     <= 1'b1;
						found            <= res_found_q;
						exact            <= res_exact_q;
						match_addr       <= res_rec_q.addr;
						match_name_ref   <= res_rec_q.name_ref;
						match_layout_ref <= res_rec_q.layout_ref;
						table_full       <= res_full_q;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/sapt_ram.sv -----
`timescale 1ns / 1ps
module sapt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- test/sorted_address_predecessor_table_tb.sv -----
`timescale 1ns / 1ps
module sorted_address_predecessor_table_tb;
	import sapt_pkg::*;

	// same depth as the block default, so the full-table case is reachable
	localparam int unsigned DEPTH = 256;
	// worst insert: search, then every record moved up one slot, then the write
	localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 64;
	localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
	localparam logic [REF_W-1:0] REF_MAX = '1;

	// one result beat as the block should present it
	typedef struct packed {
		logic              found;
		logic              exact;
		logic [ADDR_W-1:0] addr;
		logic [REF_W-1:0]  name_ref;
		logic [REF_W-1:0]  layout_ref;
		logic              table_full;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic              kind = KIND_INSERT;
	logic [ADDR_W-1:0] code_addr = '0;
	logic [REF_W-1:0]  name_ref = '0;
	logic [REF_W-1:0]  layout_ref = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              found;
	logic              exact;
	logic [ADDR_W-1:0] match_addr;
	logic [REF_W-1:0]  match_name_ref;
	logic [REF_W-1:0]  match_layout_ref;
	logic              table_full;

	// shadow copy of the sorted record store, ties kept in arrival order
	sapt_rec_t         shadow_recs [DEPTH];
	int unsigned       shadow_count = 0;
	answer_t           pending_results [$];
	int unsigned       mismatches = 0;
	// when set, the sender never idles and the receiver stops stalling once its current run ends
	logic              no_idle = 1'b0;
	int unsigned       stall_hold = 0;
	// inserts near this base give dense, colliding addresses
	logic [ADDR_W-1:0] cluster_base;

	sorted_address_predecessor_table #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.kind(kind),
		.code_addr(code_addr),
		.name_ref(name_ref),
		.layout_ref(layout_ref),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.found(found),
		.exact(exact),
		.match_addr(match_addr),
		.match_name_ref(match_name_ref),
		.match_layout_ref(match_layout_ref),
		.table_full(table_full)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// records whose address is at or below the key
	function automatic int unsigned count_at_or_below(input logic [ADDR_W-1:0] key);
		int unsigned n;
		n = 0;
		while (n < shadow_count && shadow_recs[n].addr <= key)
			n++;
		return n;
	endfunction

	// updates the shadow store and returns the beat this item must produce
	function automatic answer_t predict_answer(input logic k, input logic [ADDR_W-1:0] a,
			input logic [REF_W-1:0] nref, input logic [REF_W-1:0] lref);
		answer_t     ans;
		int unsigned pos;
		int unsigned first;
		ans = '0;
		if (k == KIND_INSERT) begin
			if (shadow_count >= DEPTH) begin
				// full store drops the record
				ans.table_full = 1'b1;
			end else begin
				// new record goes after every equal address
				pos = count_at_or_below(a);
				for (int unsigned i = shadow_count; i > pos; i--)
					shadow_recs[i] = shadow_recs[i - 1];
				shadow_recs[pos].addr = a;
				shadow_recs[pos].name_ref = nref;
				shadow_recs[pos].layout_ref = lref;
				shadow_count++;
			end
		end else begin
			pos = count_at_or_below(a);
			// nothing at or below the query leaves the beat all zero
			if (pos > 0) begin
				// walk back to the oldest record with the predecessor address
				first = pos - 1;
				while (first > 0 && shadow_recs[first - 1].addr == shadow_recs[pos - 1].addr)
					first--;
				ans.found = 1'b1;
				ans.exact = (shadow_recs[first].addr == a);
				ans.addr = shadow_recs[first].addr;
				ans.name_ref = shadow_recs[first].name_ref;
				ans.layout_ref = shadow_recs[first].layout_ref;
			end
		end
		return ans;
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		return wide[ADDR_W-1:0];
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// insert addresses: repeats of stored ones, dense cluster, or anywhere
	function automatic logic [ADDR_W-1:0] pick_insert_addr();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 25 && shadow_count > 0)
			return shadow_recs[$urandom_range(0, shadow_count - 1)].addr;
		if (r < 55)
			return cluster_base + ADDR_W'($urandom_range(0, 63));
		return rand_addr();
	endfunction

	// queries land on, just under or just over stored addresses most of the time
	function automatic logic [ADDR_W-1:0] pick_query();
		int unsigned       r;
		logic [ADDR_W-1:0] near;
		r = $urandom_range(0, 99);
		if (shadow_count == 0 || r >= 80) begin
			if (r >= 95)
				return ADDR_MAX;
			if (r >= 90)
				return '0;
			return rand_addr();
		end
		near = shadow_recs[$urandom_range(0, shadow_count - 1)].addr;
		if (r < 40)
			return near;
		if (r < 60)
			return near - ADDR_W'(1);
		return near + ADDR_W'(1);
	endfunction

	// drive one beat, hold it until taken, then maybe idle
	task automatic send_item(input logic k, input logic [ADDR_W-1:0] a,
			input logic [REF_W-1:0] nref, input logic [REF_W-1:0] lref);
		int unsigned gap;
		item_valid <= 1'b1;
		kind <= k;
		code_addr <= a;
		name_ref <= nref;
		layout_ref <= lref;
		do
			@(posedge clk);
		while (item_stall);
		pending_results.push_back(predict_answer(k, a, nref, lref));
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_lookup(input logic [ADDR_W-1:0] a);
		send_item(KIND_LOOKUP, a, $urandom(), $urandom());
	endtask

	// lookups before anything is stored
	task automatic test_empty_table();
		send_lookup('0);
		send_lookup(ADDR_MAX);
		send_item(KIND_LOOKUP, rand_addr(), REF_MAX, REF_MAX);
	endtask

	// field extremes, below-all query, equal addresses, exact and inexact hits
	task automatic test_directed();
		send_item(KIND_INSERT, 48'h0000_0000_1000, 32'h0000_00a1, 32'h0000_00b1);
		send_lookup(48'h0000_0000_0fff);
		send_item(KIND_INSERT, ADDR_MAX, REF_MAX, REF_MAX);
		send_item(KIND_INSERT, '0, '0, '0);
		send_item(KIND_INSERT, 48'h0000_0000_1000, 32'h0000_00a2, 32'h0000_00b2);
		send_item(KIND_INSERT, 48'h0000_0000_1000, 32'h5555_aaaa, 32'haaaa_5555);
		send_lookup('0);
		send_lookup(48'h0000_0000_0fff);
		send_lookup(48'h0000_0000_1000);
		send_lookup(48'h0000_0000_1001);
		send_lookup(ADDR_MAX);
		send_lookup(ADDR_MAX - ADDR_W'(1));
		send_item(KIND_LOOKUP, 48'haaaa_aaaa_aaaa, '0, '0);
	endtask

	// mixed traffic that grows the store toward full, idling switched in and out
	task automatic test_random_traffic(input int unsigned items);
		for (int unsigned i = 0; i < items; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 99) < 30)
				send_item(KIND_INSERT, pick_insert_addr(), $urandom(), $urandom());
			else
				send_lookup(pick_query());
		end
		no_idle = 1'b0;
	endtask

	// fill whatever room is left, then inserts must bounce
	task automatic test_full_table();
		while (shadow_count < DEPTH)
			send_item(KIND_INSERT, pick_insert_addr(), $urandom(), $urandom());
		for (int unsigned i = 0; i < 12; i++) begin
			send_item(KIND_INSERT, rand_addr(), $urandom(), $urandom());
			send_lookup(pick_query());
		end
		send_item(KIND_INSERT, ADDR_MAX, REF_MAX, REF_MAX);
		send_lookup('0);
		send_lookup(ADDR_MAX);
	endtask

	// receiver: runs of stall and no stall of random length
	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else if (no_idle) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(0, 2) == 0);
			stall_hold <= idle_len();
		end
	end

	// result check against the oldest waiting prediction
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing expected", $realtime);
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found || exact !== want.exact ||
						match_addr !== want.addr || match_name_ref !== want.name_ref ||
						match_layout_ref !== want.layout_ref ||
						table_full !== want.table_full) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: mismatch exp found=%b exact=%b addr=%h name=%h layout=%h full=%b",
							$realtime, want.found, want.exact, want.addr, want.name_ref,
							want.layout_ref, want.table_full);
						$display("%0t:          got found=%b exact=%b addr=%h name=%h layout=%h full=%b",
							$realtime, found, exact, match_addr, match_name_ref,
							match_layout_ref, table_full);
					end
				end
			end
		end
	end

	initial begin
		cluster_base = rand_addr();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_directed();
		test_random_traffic(950);
		test_full_table();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// any stray beat would show up within one worst-case item
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sapt_pkg.sv
rtl/sapt_ram.sv
rtl/sorted_address_predecessor_table.sv
test/sorted_address_predecessor_table_tb.sv
